// ----- rtl/grid_spacing_uniformity_check_macros.svh -----
// Assertion macros for the grid spacing check.
`ifndef GRID_SPACING_UNIFORMITY_CHECK_MACROS_SVH
`define GRID_SPACING_UNIFORMITY_CHECK_MACROS_SVH

// Same-cycle implication.
`define GSUC_ASSERT_IMP(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("grid spacing check: assertion failed");

// Next-cycle implication.
`define GSUC_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("grid spacing check: assertion failed");

`endif

// ----- rtl/gsuc_pkg.sv -----
`timescale 1ns / 1ps
package gsuc_pkg;
	localparam int DEF_MAX_COLUMNS = 16;
	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_COORD_BITS = 20;

	localparam int DIM_W = 5;
	localparam int LIMIT_W = 20;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int STATUS_W = 2;
	localparam int RATIO_W = 20;
	localparam int QUAL_W = 17;
	localparam int FRAC_BITS = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_LIMIT = 2'd2;

	localparam logic [DIM_W-1:0] COLUMNS_RESET = 5'd8;
	localparam logic [DIM_W-1:0] ROWS_RESET = 5'd6;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd13107;
	localparam logic [RATIO_W-1:0] UNIT_RATIO = 20'd65536;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd2;

	typedef struct packed {
		logic load;
		logic sel_up;
		logic square;
		logic sqrt_narrow;
		logic sqrt_wide;
		logic store_dist;
		logic commit;
		logic set_mismatch;
		logic set_unit;
		logic pass_start;
		logic pass_step;
		logic var_mul;
		logic div_ratio;
		logic take_ratio;
		logic div_qual;
		logic take_qual;
		logic zero_qual;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_grid;
		logic has_left;
		logic has_up;
		logic last;
		logic count_ok;
		logic degenerate;
		logic pass_busy;
		logic sqrt_busy;
		logic sqrt_done;
		logic div_done;
		logic ratio_below;
		logic out_busy;
	} sts_t;
endpackage

// ----- rtl/gsuc_ram.sv -----
`timescale 1ns / 1ps
module gsuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/gsuc_sqrt.sv -----
`timescale 1ns / 1ps
module gsuc_sqrt #(
	parameter int RAD_W = 94,
	parameter int NAR_W = 42
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               narrow,
	input  logic [RAD_W-1:0]   radicand,
	output logic               busy,
	output logic               done,
	output logic [RAD_W/2-1:0] root
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int NAR_PAIRS = NAR_W / 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  op_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [ROOT_W+2:0] trial_rem;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              ge;

	assign trial_rem = {rem_q, op_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge = trial_rem >= trial;
	assign diff = trial_rem - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= narrow ? CNT_W'(NAR_PAIRS) : CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				done_q <= cnt_q == CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= narrow ? (radicand << (RAD_W - NAR_W)) : radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			op_q <= op_q << 2;
			rem_q <= ge ? diff[ROOT_W:0] : trial_rem[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign root = root_q;
endmodule

// ----- rtl/gsuc_div.sv -----
`timescale 1ns / 1ps
module gsuc_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 30,
	parameter int QUO_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quot
);
	localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             sat;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign sat = CMP_W'(num) >= (CMP_W'(den) << QUO_W);
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= sat ? '0 : CNT_W'(QUO_W);
				done_q <= sat;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				done_q <= cnt_q == CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			low_q <= num[QUO_W-1:0];
			den_q <= den;
			quot_q <= sat ? '1 : '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			low_q <= low_q << 1;
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ----- rtl/gsuc_datapath.sv -----
`timescale 1ns / 1ps
`include "grid_spacing_uniformity_check_macros.svh"
module gsuc_datapath #(
	parameter int MAX_COLUMNS = gsuc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = gsuc_pkg::DEF_MAX_ROWS,
	parameter int COORD_BITS = gsuc_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [gsuc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gsuc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [COORD_BITS-1:0]            corner_x,
	input  logic [COORD_BITS-1:0]            corner_y,
	input  logic                             last_corner,
	input  gsuc_pkg::cmd_t                   cmd,
	output gsuc_pkg::sts_t                   sts,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gsuc_pkg::STATUS_W-1:0]    status,
	output logic                             passed,
	output logic [gsuc_pkg::RATIO_W-1:0]     spread_ratio,
	output logic [gsuc_pkg::QUAL_W-1:0]      quality
);
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int COLCNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int DIST_DEPTH = 2 * MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DIST_DEPTH);
	localparam int NUM_W = $clog2(DIST_DEPTH + 1);
	localparam int DIST_W = COORD_BITS + 1;
	localparam int SUM_W = DIST_W + ADDR_W;
	localparam int SQ_W = 2 * DIST_W + ADDR_W;
	localparam int VAR_W = NUM_W + SQ_W;
	localparam int TGT_W = VAR_W + 2 * gsuc_pkg::FRAC_BITS;
	localparam int RAD_W = TGT_W + (TGT_W % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int NAR_W = 2 * COORD_BITS + 2;
	localparam int QNUM_W = gsuc_pkg::RATIO_W + gsuc_pkg::FRAC_BITS;
	localparam int DNUM_W = (ROOT_W > QNUM_W) ? ROOT_W : QNUM_W;
	localparam int DDEN_W = (SUM_W > gsuc_pkg::RATIO_W) ? SUM_W : gsuc_pkg::RATIO_W;
	localparam int PROD_W = ROW_W + COLCNT_W;

	logic [gsuc_pkg::DIM_W-1:0]    cols_cfg_q;
	logic [gsuc_pkg::DIM_W-1:0]    rows_cfg_q;
	logic [gsuc_pkg::LIMIT_W-1:0]  limit_cfg_q;
	logic [COLCNT_W-1:0]           cols_eff;
	logic [ROW_W-1:0]              rows_eff;
	logic [gsuc_pkg::LIMIT_W-1:0]  lim_eff;

	logic [COORD_BITS-1:0]         cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic                          last_q;
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;
	logic [ADDR_W-1:0]             ccount_q;
	logic [NUM_W-1:0]              dcount_q;
	logic [SUM_W-1:0]              dsum_q;
	logic [2*COORD_BITS-1:0]       above_rdata;
	logic [COORD_BITS-1:0]         ref_x, ref_y, dx, dy;
	logic [2*COORD_BITS-1:0]       sqx_q, sqy_q;

	logic [NUM_W-1:0]              idx_q;
	logic                          rdv_s1, sqv_s2;
	logic [DIST_W-1:0]             dist_rdata;
	logic [2*DIST_W-1:0]           sq_s2;
	logic [SQ_W-1:0]               acc_q;
	logic [VAR_W-1:0]              nsq_q;
	logic [2*SUM_W-1:0]            s2_q;
	logic [VAR_W-1:0]              var_diff;

	logic                          sqrt_start, sqrt_busy, sqrt_done;
	logic [RAD_W-1:0]              radicand;
	logic [ROOT_W-1:0]             root;
	logic                          div_start, div_done;
	logic [DNUM_W-1:0]             div_num;
	logic [DDEN_W-1:0]             div_den;
	logic [gsuc_pkg::RATIO_W-1:0]  div_quot;

	logic [gsuc_pkg::STATUS_W-1:0] code_q;
	logic [gsuc_pkg::RATIO_W-1:0]  ratio_q;
	logic [gsuc_pkg::QUAL_W-1:0]   qual_q;
	logic                          out_valid_q;
	logic [gsuc_pkg::STATUS_W-1:0] status_q;
	logic                          passed_q;
	logic [gsuc_pkg::RATIO_W-1:0]  ratio_out_q;
	logic [gsuc_pkg::QUAL_W-1:0]   qual_out_q;

	logic                          in_grid, col_wrap, col_end, dist_room;
	logic [PROD_W-1:0]             grid_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= gsuc_pkg::COLUMNS_RESET;
			rows_cfg_q <= gsuc_pkg::ROWS_RESET;
			limit_cfg_q <= gsuc_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsuc_pkg::REG_GRID_COLUMNS: cols_cfg_q <= cfg_data[gsuc_pkg::DIM_W-1:0];
				gsuc_pkg::REG_GRID_ROWS: rows_cfg_q <= cfg_data[gsuc_pkg::DIM_W-1:0];
				gsuc_pkg::REG_SPREAD_LIMIT: limit_cfg_q <= cfg_data[gsuc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_eff = COLCNT_W'(1);
		end else if (int'(cols_cfg_q) > MAX_COLUMNS) begin
			cols_eff = COLCNT_W'(MAX_COLUMNS);
		end else begin
			cols_eff = COLCNT_W'(cols_cfg_q);
		end
		if (rows_cfg_q == '0) begin
			rows_eff = ROW_W'(1);
		end else if (int'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = ROW_W'(rows_cfg_q);
		end
		lim_eff = (limit_cfg_q == '0) ? gsuc_pkg::LIMIT_W'(1) : limit_cfg_q;
	end

	assign in_grid = row_q < rows_eff;
	assign col_wrap = COLCNT_W'(col_q) >= cols_eff;
	assign col_end = (COLCNT_W'(col_q) + COLCNT_W'(1)) >= cols_eff;
	assign dist_room = dcount_q < NUM_W'(DIST_DEPTH);
	assign grid_size = PROD_W'(rows_eff) * PROD_W'(cols_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ccount_q <= '0;
			dcount_q <= '0;
			dsum_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			last_q <= 1'b0;
		end else if (cmd.load) begin
			last_q <= last_corner;
			if (col_wrap) begin
				col_q <= '0;
				if (row_q < ROW_W'(MAX_ROWS)) begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end else if (cmd.store_dist) begin
			if (dist_room) begin
				dcount_q <= dcount_q + NUM_W'(1);
				dsum_q <= dsum_q + SUM_W'(root[DIST_W-1:0]);
			end
		end else if (cmd.commit) begin
			if (in_grid) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			if (ccount_q != ADDR_W'(DIST_DEPTH - 1)) begin
				ccount_q <= ccount_q + ADDR_W'(1);
			end
		end else if (cmd.emit) begin
			col_q <= '0;
			row_q <= '0;
			ccount_q <= '0;
			dcount_q <= '0;
			dsum_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= corner_x;
			cur_y_q <= corner_y;
		end
	end

	gsuc_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_COLUMNS)
	) u_row_ram (
		.clk(clk),
		.we(cmd.commit && in_grid),
		.waddr(col_q),
		.wdata({cur_y_q, cur_x_q}),
		.raddr(col_q),
		.rdata(above_rdata)
	);

	always_comb begin
		ref_x = cmd.sel_up ? above_rdata[COORD_BITS-1:0] : prev_x_q;
		ref_y = cmd.sel_up ? above_rdata[2*COORD_BITS-1:COORD_BITS] : prev_y_q;
		dx = (ref_x > cur_x_q) ? ref_x - cur_x_q : cur_x_q - ref_x;
		dy = (ref_y > cur_y_q) ? ref_y - cur_y_q : cur_y_q - ref_y;
	end

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= dx * dx;
			sqy_q <= dy * dy;
		end
	end

	gsuc_ram #(
		.WIDTH(DIST_W),
		.DEPTH(DIST_DEPTH)
	) u_dist_ram (
		.clk(clk),
		.we(cmd.store_dist && dist_room),
		.waddr(dcount_q[ADDR_W-1:0]),
		.wdata(root[DIST_W-1:0]),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(dist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rdv_s1 <= 1'b0;
			sqv_s2 <= 1'b0;
		end else if (cmd.pass_start) begin
			idx_q <= '0;
			rdv_s1 <= 1'b0;
			sqv_s2 <= 1'b0;
		end else if (cmd.pass_step) begin
			rdv_s1 <= idx_q < dcount_q;
			if (idx_q < dcount_q) begin
				idx_q <= idx_q + NUM_W'(1);
			end
			sqv_s2 <= rdv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			acc_q <= '0;
		end else if (cmd.pass_step) begin
			sq_s2 <= dist_rdata * dist_rdata;
			if (sqv_s2) begin
				acc_q <= acc_q + SQ_W'(sq_s2);
			end
		end
		if (cmd.var_mul) begin
			nsq_q <= dcount_q * acc_q;
			s2_q <= dsum_q * dsum_q;
		end
	end

	assign var_diff = (nsq_q >= VAR_W'(s2_q)) ? nsq_q - VAR_W'(s2_q) : '0;
	assign sqrt_start = cmd.sqrt_narrow || cmd.sqrt_wide;
	assign radicand = cmd.sqrt_wide
		? (RAD_W'(var_diff) << (2 * gsuc_pkg::FRAC_BITS))
		: RAD_W'(NAR_W'(sqx_q) + NAR_W'(sqy_q));

	gsuc_sqrt #(
		.RAD_W(RAD_W),
		.NAR_W(NAR_W)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.narrow(cmd.sqrt_narrow),
		.radicand(radicand),
		.busy(sqrt_busy),
		.done(sqrt_done),
		.root(root)
	);

	assign div_start = cmd.div_ratio || cmd.div_qual;
	assign div_num = cmd.div_qual
		? (DNUM_W'(lim_eff - ratio_q) << gsuc_pkg::FRAC_BITS)
		: DNUM_W'(root);
	assign div_den = cmd.div_qual ? DDEN_W'(lim_eff) : DDEN_W'(dsum_q);

	gsuc_div #(
		.NUM_W(DNUM_W),
		.DEN_W(DDEN_W),
		.QUO_W(gsuc_pkg::RATIO_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.pass_start) begin
			code_q <= gsuc_pkg::STATUS_OK;
		end else if (cmd.set_mismatch) begin
			code_q <= gsuc_pkg::STATUS_MISMATCH;
			ratio_q <= '0;
			qual_q <= '0;
		end else if (cmd.set_unit) begin
			code_q <= gsuc_pkg::STATUS_DEGENERATE;
			ratio_q <= gsuc_pkg::UNIT_RATIO;
		end else if (cmd.take_ratio) begin
			ratio_q <= div_quot;
		end else if (cmd.take_qual) begin
			qual_q <= div_quot[gsuc_pkg::QUAL_W-1:0];
		end else if (cmd.zero_qual) begin
			qual_q <= '0;
		end
		if (cmd.emit) begin
			status_q <= code_q;
			passed_q <= (code_q == gsuc_pkg::STATUS_OK) && (ratio_q <= lim_eff);
			ratio_out_q <= ratio_q;
			qual_out_q <= qual_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.in_grid = in_grid;
		sts.has_left = col_q != '0;
		sts.has_up = row_q != '0;
		sts.last = last_q;
		sts.count_ok = 32'(ccount_q) == 32'(grid_size);
		sts.degenerate = (dcount_q == '0) || (dsum_q == '0);
		sts.pass_busy = (idx_q < dcount_q) || rdv_s1 || sqv_s2;
		sts.sqrt_busy = sqrt_busy;
		sts.sqrt_done = sqrt_done;
		sts.div_done = div_done;
		sts.ratio_below = ratio_q < lim_eff;
		sts.out_busy = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign passed = passed_q;
	assign spread_ratio = ratio_out_q;
	assign quality = qual_out_q;

	`GSUC_ASSERT_IMP(a_out_rise_from_emit, clk, arst_n, $rose(out_valid_q), $past(cmd.emit))
	`GSUC_ASSERT_IMP(a_dist_count_bound, clk, arst_n, cmd.store_dist, dcount_q <= NUM_W'(DIST_DEPTH))
	`GSUC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(status_q))
endmodule

// ----- rtl/gsuc_ctrl.sv -----
`timescale 1ns / 1ps
`include "grid_spacing_uniformity_check_macros.svh"
module gsuc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gsuc_pkg::sts_t sts,
	output gsuc_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ROUTE  = 4'd1;
	localparam logic [3:0] S_DSQ    = 4'd2;
	localparam logic [3:0] S_DGO    = 4'd3;
	localparam logic [3:0] S_DWAIT  = 4'd4;
	localparam logic [3:0] S_COMMIT = 4'd5;
	localparam logic [3:0] S_CHECK  = 4'd6;
	localparam logic [3:0] S_PASS   = 4'd7;
	localparam logic [3:0] S_VMUL   = 4'd8;
	localparam logic [3:0] S_VGO    = 4'd9;
	localparam logic [3:0] S_VWAIT  = 4'd10;
	localparam logic [3:0] S_DIVR   = 4'd11;
	localparam logic [3:0] S_RWAIT  = 4'd12;
	localparam logic [3:0] S_QSTART = 4'd13;
	localparam logic [3:0] S_QWAIT  = 4'd14;
	localparam logic [3:0] S_EMIT   = 4'd15;

	logic [3:0] state_q, state_d;
	logic       up_q, up_d;

	always_comb begin
		state_d = state_q;
		up_d = up_q;
		cmd = '0;
		cmd.sel_up = up_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_ROUTE;
				end
			end
			S_ROUTE: begin
				if (sts.in_grid && sts.has_left) begin
					up_d = 1'b0;
					state_d = S_DSQ;
				end else if (sts.in_grid && sts.has_up) begin
					up_d = 1'b1;
					state_d = S_DSQ;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_DSQ: begin
				cmd.square = 1'b1;
				state_d = S_DGO;
			end
			S_DGO: begin
				cmd.sqrt_narrow = 1'b1;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.sqrt_done) begin
					cmd.store_dist = 1'b1;
					if (!up_q && sts.has_up) begin
						up_d = 1'b1;
						state_d = S_DSQ;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = sts.last ? S_CHECK : S_IDLE;
			end
			S_CHECK: begin
				if (!sts.count_ok) begin
					cmd.set_mismatch = 1'b1;
					state_d = S_EMIT;
				end else if (sts.degenerate) begin
					cmd.set_unit = 1'b1;
					state_d = S_QSTART;
				end else begin
					cmd.pass_start = 1'b1;
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				cmd.pass_step = 1'b1;
				if (!sts.pass_busy) begin
					state_d = S_VMUL;
				end
			end
			S_VMUL: begin
				cmd.var_mul = 1'b1;
				state_d = S_VGO;
			end
			S_VGO: begin
				cmd.sqrt_wide = 1'b1;
				state_d = S_VWAIT;
			end
			S_VWAIT: begin
				if (sts.sqrt_done) begin
					state_d = S_DIVR;
				end
			end
			S_DIVR: begin
				cmd.div_ratio = 1'b1;
				state_d = S_RWAIT;
			end
			S_RWAIT: begin
				if (sts.div_done) begin
					cmd.take_ratio = 1'b1;
					state_d = S_QSTART;
				end
			end
			S_QSTART: begin
				if (sts.ratio_below) begin
					cmd.div_qual = 1'b1;
					state_d = S_QWAIT;
				end else begin
					cmd.zero_qual = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_QWAIT: begin
				if (sts.div_done) begin
					cmd.take_qual = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			up_q <= 1'b0;
		end else begin
			state_q <= state_d;
			up_q <= up_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	`GSUC_ASSERT_NEXT(a_load_routes, clk, arst_n, cmd.load, state_q == S_ROUTE)
	`GSUC_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !sts.out_busy)
	`GSUC_ASSERT_IMP(a_sqrt_idle, clk, arst_n, cmd.sqrt_narrow || cmd.sqrt_wide, !sts.sqrt_busy)
endmodule

// ----- rtl/grid_spacing_uniformity_check.sv -----
`timescale 1ns / 1ps
// Grid spacing check: corners arrive one request at a time in row-major order and the block
// is busy (in_stall high) while it works on each. Each distance to the left or upper
// neighbour is taken by the single digit-by-digit square root unit that computes one result
// bit per cycle. After the last corner, for a grid of the right size that is not degenerate,
// the block walks the distance memory (n distances, one read per cycle) and takes the wide
// square root of the variance; it then runs up to two divisions, each with a 20-bit quotient,
// for the ratio and quality. The distance memory is tracked by a fill
// count, so no clearing pass follows reset. One result is held in an output register; the
// next set can be taken while it waits.
module grid_spacing_uniformity_check #(
	parameter int MAX_COLUMNS = gsuc_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = gsuc_pkg::DEF_MAX_ROWS,
	parameter int COORD_BITS = gsuc_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gsuc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gsuc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [COORD_BITS-1:0]            corner_x,
	input  logic [COORD_BITS-1:0]            corner_y,
	input  logic                             last_corner,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gsuc_pkg::STATUS_W-1:0]    status,
	output logic                             passed,
	output logic [gsuc_pkg::RATIO_W-1:0]     spread_ratio,
	output logic [gsuc_pkg::QUAL_W-1:0]      quality
);
	gsuc_pkg::cmd_t cmd;
	gsuc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	gsuc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	gsuc_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.COORD_BITS(COORD_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.corner_x(corner_x),
		.corner_y(corner_y),
		.last_corner(last_corner),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.passed(passed),
		.spread_ratio(spread_ratio),
		.quality(quality)
	);
endmodule
